// ===== design/rgse_pkg.sv =====
// rgse_pkg: shared types, constants and the gray conversion function for the
// RGB-to-gray Sobel edge block. No dependencies.

package rgse_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int MIN_DIM        = 3;

    localparam int PIX_W      = 8;
    localparam int CFG_W_W    = 12;
    localparam int CFG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 11;
    localparam int LINE_W     = 2 * PIX_W;   // {older row, previous row}

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // 16-bit fixed-point luma weights, summing to 65536
    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]     edge_res;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 frame_last;
    } out_word_t;

    // per-pixel control carried from the accept stage to the kernel stage
    typedef struct packed {
        logic emit;      // centre is inside the frame and gets a word
        logic interior;  // centre is not a border centre
        logic last;      // last word of the frame
    } pix_ctrl_t;

    function automatic logic [PIX_W-1:0] gray_of(input in_word_t px);
        logic [24:0] acc;
        acc = 25'(W_RED * px.red) + 25'(W_GREEN * px.green) + 25'(W_BLUE * px.blue);
        return acc[23:16];
    endfunction

endpackage

// ===== design/rgse_line_mem.sv =====
// rgse_line_mem: single-port-write, single-port-read line memory with a
// registered read. Holds the gray values of the two previous rows. Uses rgse_pkg.

module rgse_line_mem #(
    parameter int DEPTH = rgse_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(rgse_pkg::MAX_WIDTH_DEF)
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [rgse_pkg::LINE_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [rgse_pkg::LINE_W-1:0] wr_data
);

    logic [rgse_pkg::LINE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while the consuming stage is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/rgse_kernel.sv =====
// rgse_kernel: two-column window registers and the 3x3 Sobel magnitude with saturation.
// The right column comes from the line memory and the new gray pixel. Uses rgse_pkg.

module rgse_kernel (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  rgse_pkg::pix_ctrl_t        ctrl,
    input  logic [rgse_pkg::PIX_W-1:0] top,
    input  logic [rgse_pkg::PIX_W-1:0] mid,
    input  logic [rgse_pkg::PIX_W-1:0] bot,
    output logic [rgse_pkg::PIX_W-1:0] edge_val
);

    // columns: 0 = left, 1 = centre; rows: 0 top, 1 mid, 2 bottom
    logic [rgse_pkg::PIX_W-1:0] win_reg [2][3];

    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic        [11:0] ax;
    logic        [11:0] ay;
    logic        [12:0] mag;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg[0][0] <= win_reg[1][0];
            win_reg[0][1] <= win_reg[1][1];
            win_reg[0][2] <= win_reg[1][2];
            win_reg[1][0] <= top;
            win_reg[1][1] <= mid;
            win_reg[1][2] <= bot;
        end
    end

    always_comb begin
        gx = 12'(signed'({4'd0, top}) + 12'(signed'({4'd0, mid})) * 2 + signed'({4'd0, bot}))
           - 12'(signed'({4'd0, win_reg[0][0]}) + 12'(signed'({4'd0, win_reg[0][1]})) * 2
                 + signed'({4'd0, win_reg[0][2]}));
        gy = 12'(signed'({4'd0, win_reg[0][0]}) + 12'(signed'({4'd0, win_reg[1][0]})) * 2
                 + signed'({4'd0, top}))
           - 12'(signed'({4'd0, win_reg[0][2]}) + 12'(signed'({4'd0, win_reg[1][2]})) * 2
                 + signed'({4'd0, bot}));
        ax  = gx[11] ? 12'(-gx) : 12'(gx);
        ay  = gy[11] ? 12'(-gy) : 12'(gy);
        mag = {1'b0, ax} + {1'b0, ay};
        if (!ctrl.interior) begin
            edge_val = '0;
        end else if (mag > 13'(rgse_pkg::EDGE_MAX)) begin
            edge_val = rgse_pkg::EDGE_MAX;
        end else begin
            edge_val = mag[rgse_pkg::PIX_W-1:0];
        end
    end

endmodule

// ===== design/rgse_top_unused_guard.sv =====
// rgse_ctrl: frame position counters with run-time clamping of the image size
// registers, and the per-pixel control flags. Uses rgse_pkg.

module rgse_ctrl #(
    parameter int MAX_WIDTH  = rgse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgse_pkg::MAX_HEIGHT_DEF,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [rgse_pkg::CFG_W_W-1:0] image_width,
    input  logic [rgse_pkg::CFG_H_W-1:0] image_height,
    output logic [CW-1:0]                col,
    output logic [CW-1:0]                cent_col,
    output logic [RW-1:0]                cent_row,
    output rgse_pkg::pix_ctrl_t          ctrl
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW:0]   w_eff;
    logic [RW:0]   h_eff;
    logic [RW-1:0] row;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;

    always_comb begin
        if (image_width < rgse_pkg::CFG_W_W'(rgse_pkg::MIN_DIM)) begin
            w_eff = (CW+1)'(rgse_pkg::MIN_DIM);
        end else if (32'(image_width) > MAX_WIDTH) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(image_width);
        end
        if (image_height < rgse_pkg::CFG_H_W'(rgse_pkg::MIN_DIM)) begin
            h_eff = (RW+1)'(rgse_pkg::MIN_DIM);
        end else if (32'(image_height) > MAX_HEIGHT) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(image_height);
        end

        // wrap early if the size registers shrank under the counters
        col = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        row = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;
        col_inc = {1'b0, col} + 1'b1;
        row_inc = {1'b0, row} + 1'b1;

        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
        end else begin
            col_next = col_inc[CW-1:0];
            row_next = row;
        end

        cent_col      = col - 1'b1;
        cent_row      = row - 1'b1;
        ctrl.emit     = (row != '0) && (col != '0);
        ctrl.interior = (row > RW'(1)) && (col > CW'(1));
        ctrl.last     = (row_inc == h_eff) && (col_inc == w_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== design/rgb_gray_sobel_edge.sv =====
// rgb_gray_sobel_edge: RGB to gray conversion and 3x3 Sobel edge magnitude.
//
// Usage:
//   s_ channel: one RGB pixel word per transfer, raster order, valid/ready.
//   m_ channel: one edge word for each pixel at row >= 1 and column >= 1,
//     tagged with the centre position (row-1, col-1) and a frame_last flag.
//     Border centres give 0; the last row and column of centres are not sent.
//   cfg port: cfg_we/cfg_index/cfg_wdata write image_width (0) and
//     image_height (1); write only while the block is idle.
// Throughput: one pixel per clock while m_ready keeps the output draining. The line
//   memory read and the gray value register with the pixel at accept; the kernel
//   result then registers into the m_ output word when the kernel stage advances.
// Reset (aresetn, synchronous, low): position counters return to the frame
//   start, size registers to 640x480, pipeline emptied. Line memory is not
//   cleared; no pass is needed since edge rows never read unwritten entries.
// Stall: while m_ready is low the output word holds; pixels are taken until the
//   kernel stage holds one that gets a word, then s_ready drops until the output drains.
// Depends on rgse_pkg, rgse_ctrl, rgse_line_mem, rgse_kernel.

module rgb_gray_sobel_edge #(
    parameter int MAX_WIDTH  = rgse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgse_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rgse_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rgse_pkg::out_word_t             m_data,
    input  logic                            cfg_we,
    input  logic [rgse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgse_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [rgse_pkg::CFG_W_W-1:0] width_reg;
    logic [rgse_pkg::CFG_H_W-1:0] height_reg;

    logic                s_acc;
    logic [CW-1:0]       col;
    logic [CW-1:0]       cent_col;
    logic [RW-1:0]       cent_row;
    rgse_pkg::pix_ctrl_t ctrl;

    // kernel stage
    logic                       p1_valid_reg;
    rgse_pkg::pix_ctrl_t        p1_ctrl_reg;
    logic [rgse_pkg::PIX_W-1:0] p1_gray_reg;
    logic [CW-1:0]              p1_addr_reg;
    logic [CW-1:0]              p1_col_reg;
    logic [RW-1:0]              p1_row_reg;

    logic [rgse_pkg::LINE_W-1:0] line_rd;
    logic [rgse_pkg::PIX_W-1:0]  top;
    logic [rgse_pkg::PIX_W-1:0]  mid;
    logic [rgse_pkg::PIX_W-1:0]  edge_val;
    logic                        out_free;
    logic                        p1_go;

    logic                m_valid_reg;
    rgse_pkg::out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rgse_pkg::WIDTH_RESET;
            height_reg <= rgse_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                rgse_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[rgse_pkg::CFG_W_W-1:0];
                rgse_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[rgse_pkg::CFG_H_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign p1_go    = p1_valid_reg && (!p1_ctrl_reg.emit || out_free);
    assign s_ready  = !p1_valid_reg || p1_go;
    assign s_acc    = s_valid && s_ready;

    rgse_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s_acc),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (col),
        .cent_col     (cent_col),
        .cent_row     (cent_row),
        .ctrl         (ctrl)
    );

    // read at the new column, write back the previous column: addresses never
    // collide since consecutive pixels of a row differ in column
    rgse_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col),
        .rd_data (line_rd),
        .wr_en   (p1_go),
        .wr_addr (p1_addr_reg),
        .wr_data ({mid, p1_gray_reg})
    );

    assign top = line_rd[rgse_pkg::LINE_W-1:rgse_pkg::PIX_W];
    assign mid = line_rd[rgse_pkg::PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_go) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_ctrl_reg <= ctrl;
            p1_gray_reg <= rgse_pkg::gray_of(s_data);
            p1_addr_reg <= col;
            p1_col_reg  <= cent_col;
            p1_row_reg  <= cent_row;
        end
    end

    rgse_kernel u_kernel (
        .aclk     (aclk),
        .shift_en (p1_go),
        .ctrl     (p1_ctrl_reg),
        .top      (top),
        .mid      (mid),
        .bot      (p1_gray_reg),
        .edge_val (edge_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_go && p1_ctrl_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_go && p1_ctrl_reg.emit) begin
            m_data_reg.edge_res   <= edge_val;
            m_data_reg.out_row    <= rgse_pkg::OUT_ROW_W'(p1_row_reg);
            m_data_reg.out_col    <= rgse_pkg::OUT_COL_W'(p1_col_reg);
            m_data_reg.frame_last <= p1_ctrl_reg.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_empty_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !p1_valid_reg |-> s_ready)
        else $error("input not ready with kernel stage empty");

    a_accept_fills : assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> p1_valid_reg)
        else $error("accepted word lost before kernel stage");

    a_border_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.edge_res != '0) |-> (m_data.out_row != '0) && (m_data.out_col != '0))
        else $error("nonzero edge on a border centre");

    a_word_from_stage : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(p1_valid_reg && p1_ctrl_reg.emit))
        else $error("output word without a kernel stage source");

endmodule
